/* rtl/iee_pkg.sv */
// iee_pkg: token kinds, error codes, sequencer states and the front-to-back
// record for the expression evaluator. No dependencies.
`timescale 1ns / 1ps
package iee_pkg;
    localparam int unsigned VAL_W = 64;

    typedef enum logic [2:0] {
        K_NUM = 3'd0, K_PLUS = 3'd1, K_MINUS = 3'd2, K_MUL = 3'd3,
        K_DIV = 3'd4, K_OPEN = 3'd5, K_CLOSE = 3'd6, K_NEG = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        E_OK = 2'd0, E_DIV0 = 2'd1, E_MALFORMED = 2'd2, E_OVERFLOW = 2'd3
    } t_err;

    typedef enum logic [3:0] {
        S_IDLE, S_PEEK, S_OPRD, S_APPLY, S_RDB, S_RDA, S_ARITH, S_MULW,
        S_DIVW, S_WRITE, S_PUSH, S_FINRD, S_FINWAIT, S_OUT
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic [VAL_W-1:0]  value;
        logic              last;
        logic [2:0]        prio;
    } t_tok;

    localparam logic [VAL_W-1:0] SIGN_BIT = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] MAX_POS  = {1'b0, {(VAL_W-1){1'b1}}};

    function automatic logic [2:0] prio_of(t_kind k);
        case (k)
            K_OPEN:          prio_of = 3'd0;
            K_CLOSE:         prio_of = 3'd1;
            K_PLUS, K_MINUS: prio_of = 3'd2;
            K_MUL, K_DIV:    prio_of = 3'd3;
            default:         prio_of = 3'd4;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] mag_of(logic [VAL_W-1:0] v);
        mag_of = v[VAL_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [VAL_W-1:0] from_mag(logic neg, logic [VAL_W-1:0] m,
                                                  logic big);
        if (neg) begin
            from_mag = (big || m > SIGN_BIT) ? SIGN_BIT : (~m + 1'b1);
        end else begin
            from_mag = (big || m > MAX_POS) ? MAX_POS : m;
        end
    endfunction
endpackage

/* rtl/iee_stream_if.sv */
// iee_stream_if: valid/ready channel with a generic payload type.
// No dependencies.
`timescale 1ns / 1ps
interface iee_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/iee_ram.sv */
// iee_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module iee_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

/* rtl/iee_front.sv */
// iee_front: accepts tokens, classifies them (priority) and queues them
// in a two-entry FIFO for the back end. Depends on iee_pkg.
`timescale 1ns / 1ps
module iee_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [2:0]            i_token_kind,
    input  logic [63:0]           i_number_value,
    input  logic                  i_last_token,
    input  logic                  i_valid,
    output logic                  o_ready,
    output iee_pkg::t_tok         o_tok,
    output logic                  o_tok_valid,
    input  logic                  i_tok_pop
);
    import iee_pkg::*;

    t_tok       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_tok       n_tok;
    logic       push;

    always_comb begin
        n_tok.kind  = t_kind'(i_token_kind);
        n_tok.value = i_number_value;
        n_tok.last  = i_last_token;
        n_tok.prio  = prio_of(t_kind'(i_token_kind));
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_tok_valid = (r_cnt != 2'd0);
    assign o_tok       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_tok;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_tok_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_tok_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_pop |-> o_tok_valid) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp)) else $error("pointer mismatch");
endmodule

/* rtl/iee_back.sv */
// iee_back: sequencer that runs shunting-yard on the two stacks, with a
// four-step multiplier and a bit-serial divider. Depends on iee_pkg, iee_ram.
`timescale 1ns / 1ps
module iee_back #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  iee_pkg::t_tok         i_tok,
    input  logic                  i_tok_valid,
    output logic                  o_tok_pop,
    output logic [63:0]           o_expression_value,
    output logic [1:0]            o_error_code,
    output logic                  o_valid,
    input  logic                  i_ready
);
    import iee_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_ocnt, n_ocnt, r_vcnt, n_vcnt;
    t_err            r_err, n_err;
    logic            r_fin, n_fin;
    t_kind           r_op, n_op;
    logic [63:0]     r_a, n_a, r_b, n_b, r_res, n_res;
    logic [63:0]     r_ov, n_ov;
    logic [1:0]      r_oe, n_oe;
    logic            r_ovld, n_ovld;
    logic [1:0]      r_mstep, n_mstep;
    logic [127:0]    r_acc, n_acc;
    logic [6:0]      r_dstep, n_dstep;
    logic [127:0]    r_num, n_num;
    logic [63:0]     r_rem, n_rem;
    logic [63:0]     r_q, n_q;
    logic            r_big, n_big, r_neg, n_neg;

    logic            ow, vw;
    logic [AW-1:0]   oa, va;
    logic [2:0]      owd, ord_raw;
    logic [63:0]     vwd, vrd;
    t_kind           otop;
    logic [64:0]     rsh, rdif;
    logic [63:0]     ua, ub;
    logic [31:0]     msel_a, msel_b;
    logic [63:0]     pp;

    iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_ops (
        .i_clk(i_clk), .i_we(ow), .i_addr(oa), .i_wdata(owd), .o_rdata(ord_raw));
    iee_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_vals (
        .i_clk(i_clk), .i_we(vw), .i_addr(va), .i_wdata(vwd), .o_rdata(vrd));

    assign otop = t_kind'(ord_raw);
    assign ua   = mag_of(r_a);
    assign ub   = mag_of(r_b);
    assign msel_a = r_mstep[0] ? ua[63:32] : ua[31:0];
    assign msel_b = r_mstep[1] ? ub[63:32] : ub[31:0];
    assign pp   = {32'd0, msel_a} * {32'd0, msel_b};
    assign rsh  = {r_rem, r_num[127]};
    assign rdif = rsh - {1'b0, ub};

    assign o_expression_value = r_ov;
    assign o_error_code       = r_oe;
    assign o_valid            = r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ocnt  <= '0;
            r_vcnt  <= '0;
            r_err   <= E_OK;
            r_ovld  <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ocnt  <= n_ocnt;
            r_vcnt  <= n_vcnt;
            r_err   <= n_err;
            r_ovld  <= n_ovld;
            r_fin   <= n_fin;
        end
        r_op <= n_op;  r_a <= n_a;  r_b <= n_b;  r_res <= n_res;
        r_ov <= n_ov;  r_oe <= n_oe;
        r_mstep <= n_mstep; r_acc <= n_acc;
        r_dstep <= n_dstep; r_num <= n_num; r_rem <= n_rem; r_q <= n_q;
        r_big <= n_big; r_neg <= n_neg;
    end

    always_comb begin
        n_state = r_state; n_ocnt = r_ocnt; n_vcnt = r_vcnt; n_err = r_err;
        n_fin = r_fin; n_op = r_op; n_a = r_a; n_b = r_b; n_res = r_res;
        n_ov = r_ov; n_oe = r_oe; n_ovld = r_ovld;
        n_mstep = r_mstep; n_acc = r_acc; n_dstep = r_dstep; n_num = r_num;
        n_rem = r_rem; n_q = r_q; n_big = r_big; n_neg = r_neg;
        o_tok_pop = 1'b0;
        ow = 1'b0; oa = AW'(r_ocnt - 1'b1); owd = i_tok.kind;
        vw = 1'b0; va = AW'(r_vcnt - 1'b1); vwd = r_res;
        if (r_ovld && i_ready) n_ovld = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    n_fin = 1'b0;
                    if (r_err != E_OK) begin
                        n_state = i_tok.last ? S_FINRD : S_IDLE;
                        o_tok_pop = !i_tok.last;
                    end else if (i_tok.kind == K_NUM) begin
                        if (r_vcnt >= FULL) begin
                            n_err = E_OVERFLOW;
                        end else begin
                            vw = 1'b1; va = AW'(r_vcnt); vwd = i_tok.value;
                            n_vcnt = r_vcnt + 1'b1;
                        end
                        n_state = i_tok.last ? S_PEEK : S_IDLE;
                        n_fin = i_tok.last;
                        o_tok_pop = !i_tok.last;
                    end else if (i_tok.kind == K_OPEN) begin
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_PEEK;
                    end
                end
            end
            S_PEEK: begin
                if (r_err != E_OK) begin
                    n_state = r_fin ? S_FINRD : S_IDLE;
                end else if (r_ocnt == '0) begin
                    if (!r_fin && i_tok.kind == K_CLOSE) begin
                        n_err = E_MALFORMED;
                        n_state = i_tok.last ? S_FINRD : S_IDLE;
                        o_tok_pop = !i_tok.last;
                    end else if (r_fin) begin
                        n_state = S_FINRD;
                    end else begin
                        n_state = S_PUSH;
                    end
                end else begin
                    n_state = S_OPRD;
                end
            end
            S_OPRD: n_state = S_APPLY;
            S_APPLY: begin
                if (!r_fin && i_tok.kind == K_CLOSE && otop == K_OPEN) begin
                    n_ocnt = r_ocnt - 1'b1;
                    n_fin = i_tok.last;
                    n_state = i_tok.last ? S_PEEK : S_IDLE;
                    o_tok_pop = !i_tok.last;
                end else if (!r_fin && i_tok.kind != K_CLOSE &&
                             prio_of(otop) < i_tok.prio) begin
                    n_state = S_PUSH;
                end else begin
                    n_ocnt = r_ocnt - 1'b1;
                    n_op = otop;
                    if (otop == K_OPEN || otop == K_CLOSE || otop == K_NUM) begin
                        n_err = E_MALFORMED; n_state = S_PEEK;
                    end else if (otop == K_NEG) begin
                        if (r_vcnt < CW'(1)) begin
                            n_err = E_MALFORMED; n_state = S_PEEK;
                        end else n_state = S_RDB;
                    end else if (r_vcnt < CW'(2)) begin
                        n_err = E_MALFORMED; n_state = S_PEEK;
                    end else n_state = S_RDB;
                end
            end
            S_RDB: begin
                n_state = (r_op == K_NEG) ? S_ARITH : S_RDA;
                va = AW'(r_vcnt - 1'b1);
            end
            S_RDA: begin
                n_b = vrd;
                va = AW'(r_vcnt - CW'(2));
                n_state = S_ARITH;
            end
            S_ARITH: begin
                if (r_op == K_NEG) begin
                    n_a = vrd;
                    n_res = (vrd == SIGN_BIT) ? MAX_POS : (~vrd + 1'b1);
                    vw = 1'b1; va = AW'(r_vcnt - 1'b1);
                    vwd = (vrd == SIGN_BIT) ? MAX_POS : (~vrd + 1'b1);
                    n_state = S_PEEK;
                end else begin
                    n_a = vrd;
                    n_neg = vrd[63] ^ r_b[63];
                    n_state = S_WRITE;
                    case (r_op)
                        K_PLUS: begin
                            n_res = vrd + r_b;
                            if (vrd[63] == r_b[63] && n_res[63] != vrd[63])
                                n_res = vrd[63] ? SIGN_BIT : MAX_POS;
                        end
                        K_MINUS: begin
                            n_res = vrd - r_b;
                            if (vrd[63] != r_b[63] && n_res[63] != vrd[63])
                                n_res = vrd[63] ? SIGN_BIT : MAX_POS;
                        end
                        K_MUL: begin
                            n_mstep = 2'd0; n_acc = '0; n_state = S_MULW;
                        end
                        default: begin
                            if (r_b == '0) begin
                                n_err = E_DIV0; n_state = S_PEEK;
                            end else begin
                                n_num = {32'd0, mag_of(vrd), 32'd0};
                                n_rem = '0; n_q = '0; n_big = 1'b0;
                                n_dstep = 7'd0; n_state = S_DIVW;
                            end
                        end
                    endcase
                end
            end
            S_MULW: begin
                case (r_mstep)
                    2'd0: n_acc = r_acc + {64'd0, pp};
                    2'd1: n_acc = r_acc + {32'd0, pp, 32'd0};
                    2'd2: n_acc = r_acc + {32'd0, pp, 32'd0};
                    default: n_acc = r_acc + {pp, 64'd0};
                endcase
                n_mstep = r_mstep + 1'b1;
                if (r_mstep == 2'd3) begin
                    n_res = from_mag(r_neg, n_acc[95:32], n_acc[127:96] != '0);
                    n_state = S_WRITE;
                end
            end
            S_DIVW: begin
                if (r_q[63]) n_big = 1'b1;
                n_num = {r_num[126:0], 1'b0};
                if (rsh >= {1'b0, ub}) begin
                    n_rem = rdif[63:0];
                    n_q = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = rsh[63:0];
                    n_q = {r_q[62:0], 1'b0};
                end
                n_dstep = r_dstep + 1'b1;
                if (r_dstep == 7'd127) begin
                    n_res = from_mag(r_neg, n_q, n_big);
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                vw = 1'b1; va = AW'(r_vcnt - CW'(2)); vwd = r_res;
                n_vcnt = r_vcnt - 1'b1;
                n_state = S_PEEK;
            end
            S_PUSH: begin
                if (r_ocnt >= FULL) begin
                    n_err = E_OVERFLOW;
                end else begin
                    ow = 1'b1; oa = AW'(r_ocnt); owd = i_tok.kind;
                    n_ocnt = r_ocnt + 1'b1;
                end
                n_fin = i_tok.last;
                n_state = i_tok.last ? S_PEEK : S_IDLE;
                o_tok_pop = !i_tok.last;
            end
            S_FINRD: begin
                va = '0;
                n_state = S_FINWAIT;
            end
            S_FINWAIT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovld) begin
                    n_oe = (r_err == E_OK && r_vcnt > CW'(1)) ? E_MALFORMED : r_err;
                    n_ov = (n_oe == E_OK && r_vcnt == CW'(1)) ? vrd : '0;
                    n_ovld = 1'b1;
                    n_err = E_OK; n_ocnt = '0; n_vcnt = '0; n_fin = 1'b0;
                    o_tok_pop = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_ocnt <= FULL)
        else $error("operator count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_vcnt <= FULL)
        else $error("value count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !i_ready) |=> $stable(r_ov)) else $error("result changed");
endmodule

/* rtl/infix_expression_evaluator.sv */
// Top level: infix expression evaluator, front queue plus back sequencer.
// Depends on iee_pkg, iee_front, iee_back. One token in the back end at a time.
// On the last token the remaining operators are applied and the result beat is sent.
// Synchronous active-low reset clears counts, error and queue.
`timescale 1ns / 1ps
module infix_expression_evaluator #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_token_kind,
    input  logic [63:0] i_number_value,
    input  logic        i_last_token,
    input  logic        i_valid,
    output logic        o_ready,
    output logic [63:0] o_expression_value,
    output logic [1:0]  o_error_code,
    output logic        o_valid,
    input  logic        i_ready
);
    import iee_pkg::*;

    t_tok tok;
    logic tok_valid, tok_pop;

    iee_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_token_kind(i_token_kind),
        .i_number_value(i_number_value), .i_last_token(i_last_token),
        .i_valid(i_valid), .o_ready(o_ready), .o_tok(tok),
        .o_tok_valid(tok_valid), .i_tok_pop(tok_pop));

    iee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tok(tok), .i_tok_valid(tok_valid),
        .o_tok_pop(tok_pop), .o_expression_value(o_expression_value),
        .o_error_code(o_error_code), .o_valid(o_valid), .i_ready(i_ready));
endmodule

/* dv/tb_infix_expression_evaluator.sv */
// Self-checking testbench for infix_expression_evaluator: random bursts of
// token beats in, a stalling result sink, an in-bench shunting-yard predictor.
// Depends on iee_pkg, iee_stream_if and the RTL top level.
`timescale 1ns / 1ps
module tb_infix_expression_evaluator;
    import iee_pkg::*;

    localparam int DEPTH = 32;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic        last;
    } t_token;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  err;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    iee_stream_if #(.T(t_token))  tok_ch ();
    iee_stream_if #(.T(t_answer)) ans_ch ();

    infix_expression_evaluator u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_token_kind       (tok_ch.data.kind),
        .i_number_value     (tok_ch.data.value),
        .i_last_token       (tok_ch.data.last),
        .i_valid            (tok_ch.valid),
        .o_ready            (tok_ch.ready),
        .o_expression_value (ans_ch.data.value),
        .o_error_code       (ans_ch.data.err),
        .o_valid            (ans_ch.valid),
        .i_ready            (ans_ch.ready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    t_token  token_queue[$];
    t_answer answer_queue[$];
    int      mismatches = 0;
    int      idle_cycles = 0;

    // predictor state
    logic [63:0] val_stk[DEPTH];
    t_kind       op_stk[DEPTH];
    int          val_cnt, op_cnt;
    t_err        err_sticky;

    function automatic void clear_eval();
        val_cnt = 0;
        op_cnt = 0;
        err_sticky = E_OK;
    endfunction

    function automatic void flag(t_err e);
        if (err_sticky == E_OK) err_sticky = e;
    endfunction

    function automatic logic [2:0] rank(t_kind k);
        case (k)
            K_OPEN:          return 3'd0;
            K_CLOSE:         return 3'd1;
            K_PLUS, K_MINUS: return 3'd2;
            K_MUL, K_DIV:    return 3'd3;
            default:         return 3'd4;
        endcase
    endfunction

    function automatic logic [63:0] magn(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] saturate(logic neg, logic [63:0] m, logic big);
        if (neg) return (big || m > SIGN_BIT) ? SIGN_BIT : -m;
        return (big || m > MAX_POS) ? MAX_POS : m;
    endfunction

    function automatic void apply_op(t_kind k);
        logic [63:0]  a, b, r;
        logic [127:0] wide;
        logic         neg;
        if (k == K_NEG) begin
            if (val_cnt < 1) begin
                flag(E_MALFORMED);
                return;
            end
            a = val_stk[val_cnt-1];
            val_stk[val_cnt-1] = (a == SIGN_BIT) ? MAX_POS : -a;
            return;
        end
        if (k == K_OPEN || k == K_CLOSE || k == K_NUM || val_cnt < 2) begin
            flag(E_MALFORMED);
            return;
        end
        b = val_stk[val_cnt-1];
        a = val_stk[val_cnt-2];
        neg = a[63] ^ b[63];
        case (k)
            K_PLUS: begin
                r = a + b;
                if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? SIGN_BIT : MAX_POS;
            end
            K_MINUS: begin
                r = a - b;
                if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? SIGN_BIT : MAX_POS;
            end
            K_MUL: begin
                wide = {64'd0, magn(a)} * {64'd0, magn(b)};
                r = saturate(neg, wide[95:32], wide[127:96] != 0);
            end
            default: begin
                if (b == 0) begin
                    flag(E_DIV0);
                    return;
                end
                wide = {32'd0, magn(a), 32'd0} / {64'd0, magn(b)};
                r = saturate(neg, wide[63:0], wide[127:64] != 0);
            end
        endcase
        val_cnt--;
        val_stk[val_cnt-1] = r;
    endfunction

    function automatic void take_token(t_kind k, logic [63:0] v);
        if (k == K_NUM) begin
            if (val_cnt >= DEPTH) flag(E_OVERFLOW);
            else begin
                val_stk[val_cnt] = v;
                val_cnt++;
            end
            return;
        end
        if (k == K_CLOSE) begin
            forever begin
                if (err_sticky != E_OK) return;
                if (op_cnt == 0) begin
                    flag(E_MALFORMED);
                    return;
                end
                if (op_stk[op_cnt-1] == K_OPEN) break;
                op_cnt--;
                apply_op(op_stk[op_cnt]);
            end
            op_cnt--;
            return;
        end
        if (k != K_OPEN) begin
            while (err_sticky == E_OK && op_cnt > 0 && rank(op_stk[op_cnt-1]) >= rank(k)) begin
                op_cnt--;
                apply_op(op_stk[op_cnt]);
            end
            if (err_sticky != E_OK) return;
        end
        if (op_cnt >= DEPTH) flag(E_OVERFLOW);
        else begin
            op_stk[op_cnt] = k;
            op_cnt++;
        end
    endfunction

    function automatic void eval_beat(t_token t);
        t_answer ans;
        if (err_sticky == E_OK) take_token(t.kind, t.value);
        if (!t.last) return;
        while (err_sticky == E_OK && op_cnt > 0) begin
            op_cnt--;
            apply_op(op_stk[op_cnt]);
        end
        if (err_sticky == E_OK && val_cnt > 1) flag(E_MALFORMED);
        ans.err = err_sticky;
        ans.value = (err_sticky == E_OK && val_cnt == 1) ? val_stk[0] : 64'd0;
        answer_queue.insert(answer_queue.size(), ans);
        clear_eval();
    endfunction

    // stimulus helpers
    function automatic logic [63:0] pick_number();
        case ($urandom_range(0, 7))
            0:       return {$urandom, $urandom};
            1:       return SIGN_BIT;
            2:       return MAX_POS;
            3:       return 64'd0;
            4:       return {{32{1'b0}}, $urandom};
            default: return {$signed(32'($urandom_range(0, 40)) - 32'sd20), 32'd0}
                            + (64'($urandom_range(0, 3)) << 30);
        endcase
    endfunction

    function automatic void put(t_kind k, logic [63:0] v, logic last = 1'b0);
        t_token t;
        t.kind = k;
        t.value = v;
        t.last = last;
        token_queue.insert(token_queue.size(), t);
    endfunction

    function automatic void end_expr();
        token_queue[token_queue.size()-1].last = 1'b1;
    endfunction

    function automatic void gen_expr(int lvl);
        int terms;
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++) begin
            if (i > 0) put(t_kind'($urandom_range(1, 4)), {$urandom, $urandom});
            if ($urandom_range(0, 5) == 0) put(K_NEG, {$urandom, $urandom});
            if (lvl < 3 && $urandom_range(0, 3) == 0) begin
                put(K_OPEN, {$urandom, $urandom});
                gen_expr(lvl + 1);
                put(K_CLOSE, {$urandom, $urandom});
            end else begin
                put(K_NUM, pick_number());
            end
        end
    endfunction

    initial begin
        int n;
        // 1 + 2 * 3, lone number, negate the most negative value
        put(K_NUM, 64'h1_0000_0000); put(K_PLUS, '0); put(K_NUM, 64'h2_0000_0000);
        put(K_MUL, '0); put(K_NUM, 64'h3_0000_0000, 1'b1);
        put(K_NUM, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        put(K_NEG, '0); put(K_NUM, SIGN_BIT, 1'b1);
        put(K_NUM, MAX_POS); put(K_MUL, '0); put(K_NUM, MAX_POS, 1'b1);
        put(K_NUM, SIGN_BIT); put(K_DIV, '0); put(K_NUM, 64'h1, 1'b1);
        put(K_NUM, MAX_POS); put(K_MINUS, '0); put(K_NUM, SIGN_BIT, 1'b1);
        put(K_NUM, 64'h5_0000_0000); put(K_DIV, '0); put(K_NUM, '0, 1'b1);
        put(K_CLOSE, '0); put(K_NUM, 64'h1, 1'b1);
        put(K_OPEN, '0); put(K_NUM, 64'h1, 1'b1);
        put(K_NUM, 64'h1); put(K_NUM, 64'h2, 1'b1);
        put(K_PLUS, '0, 1'b1);
        put(K_OPEN, '0); put(K_NUM, 64'h7); put(K_MINUS, '0); put(K_NUM, 64'h9);
        put(K_CLOSE, '0); put(K_DIV, '0); put(K_NUM, 64'h3, 1'b1);
        for (int i = 0; i <= DEPTH; i++) put(K_NUM, 64'(i));
        end_expr();
        for (int i = 0; i <= DEPTH; i++) put(K_OPEN, '0);
        end_expr();
        while (token_queue.size() < 1650) begin
            if ($urandom_range(0, 6) == 0) begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    put(t_kind'($urandom_range(0, 7)), pick_number());
            end else begin
                gen_expr(0);
            end
            end_expr();
        end
        clear_eval();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (token_queue.size() == 0 && !tok_ch.valid);
        wait (answer_queue.size() == 0);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    // driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        logic   send;
        t_token nxt;
        if (!i_rst_n) begin
            tok_ch.valid <= 1'b0;
            tok_ch.data <= '0;
        end else if (!tok_ch.valid || tok_ch.ready) begin
            send = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (token_queue.size() > 0) begin
                send = 1'b1;
                nxt = token_queue.pop_front();
                tok_ch.data <= nxt;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            tok_ch.valid <= send;
        end
    end

    // result sink stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ans_ch.ready <= 1'b0;
        end else begin
            stall_phase++;
            case ((stall_phase / 500) % 3)
                0:       ans_ch.ready <= 1'b1;
                1:       ans_ch.ready <= ($urandom_range(0, 3) != 0);
                default: ans_ch.ready <= ((stall_phase % 7) < 3);
            endcase
        end
    end

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h expected %h", what, got, want);
    endtask

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        t_answer want;
        logic    moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (tok_ch.valid && tok_ch.ready) begin
                eval_beat(tok_ch.data);
                moved = 1'b1;
            end
            if (ans_ch.valid && ans_ch.ready) begin
                moved = 1'b1;
                if (answer_queue.size() == 0) begin
                    report("unexpected result", ans_ch.data.value, '0);
                end else begin
                    want = answer_queue.pop_front();
                    if (ans_ch.data.value !== want.value)
                        report("expression_value", ans_ch.data.value, want.value);
                    if (ans_ch.data.err !== want.err)
                        report("error_code", 64'(ans_ch.data.err), 64'(want.err));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end
endmodule
